/* hw/rtl/mrcs_pkg.sv */
package mrcs_pkg;

	// default sizes
	localparam int DEF_MAX_VERTICES = 1024;
	localparam int DEF_MAX_EDGES    = 4096;
	localparam int DEF_FRAC_BITS    = 18;

	// field widths
	localparam int KIND_W      = 2;
	localparam int ID_W        = 11;
	localparam int VAL_W       = 10;
	localparam int TIME_W      = 10;
	localparam int OUT_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int DIST_W      = 64;
	localparam int RATIO_INT_W = 14;
	localparam int VC_W        = 11;
	localparam int EC_W        = 13;
	localparam int IT_W        = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_COUNT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_UPPER  = 3'd3;

	// register reset values
	localparam logic [VC_W-1:0]        RST_VERTEX_COUNT = 11'd2;
	localparam logic [EC_W-1:0]        RST_EDGE_COUNT   = 13'd2;
	localparam logic [IT_W-1:0]        RST_ITER_COUNT   = 6'd30;
	localparam logic [RATIO_INT_W-1:0] RST_RATIO_UPPER  = 14'd10000;

	typedef enum logic [KIND_W-1:0] {
		KIND_VERTEX = 2'd0,
		KIND_EDGE   = 2'd1,
		KIND_START  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// controller steps, also the command to the datapath
	typedef enum logic [4:0] {
		OP_IDLE,
		OP_HCLR,
		OP_ARD,
		OP_AHD,
		OP_AWR,
		OP_BSET,
		OP_MID,
		OP_PCLR,
		OP_PINIT,
		OP_POP,
		OP_PX,
		OP_PX2,
		OP_PL,
		OP_PE,
		OP_PW,
		OP_PC,
		OP_PEND,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t op;
	} ctrl_cmd_t;

	typedef struct packed {
		logic start;
		logic sweep_last;
		logic edges_done;
		logic edge_in_graph;
		logic iter_done;
		logic queue_empty;
		logic link_zero;
		logic found;
		logic out_busy;
	} dp_status_t;

endpackage

/* hw/rtl/max_ratio_cycle_search.sv */
// largest value-to-time ratio over cycles reachable from vertex 1
//
// input channel (in_valid/in_ready): one word per cycle while idle.
//   kind 0 writes a vertex value, kind 1 appends an edge, kind 2 starts the
//   search, kind 3 is dropped. load words leave the block idle.
// output channel (out_valid/out_ready): one word, best_ratio in Q14.18,
//   after each start word. loads produce nothing.
// config channel (cfg_valid/cfg_ready): always ready, write only while idle.
//
// a start word first clears the adjacency heads, one vertex at a time, then
//   builds the lists edge by edge, then per bisection step clears the
//   per-vertex marks and relaxes the edges of each vertex popped from the
//   queue; the chained registered reads of the edge memory and then the
//   vertex state and distance memories set the pace of that edge scan.
// in_ready is low for the whole search. a finished word waits in the output
//   register; if the receiver stalls, the next search holds before writing
//   its own result until the previous word is taken, and no input word is
//   taken while it holds. loads are taken while only the old word waits.
// reset clears configuration to its defaults, the edge count and all
//   control state; vertex values are undefined until loaded.
module max_ratio_cycle_search #(
	parameter int MAX_VERTICES = mrcs_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = mrcs_pkg::DEF_MAX_EDGES,
	parameter int FRAC_BITS    = mrcs_pkg::DEF_FRAC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mrcs_pkg::KIND_W-1:0]     kind,
	input  logic [mrcs_pkg::ID_W-1:0]       vertex_id,
	input  logic [mrcs_pkg::VAL_W-1:0]      fun_value,
	input  logic [mrcs_pkg::ID_W-1:0]       edge_source,
	input  logic [mrcs_pkg::ID_W-1:0]       edge_target,
	input  logic [mrcs_pkg::TIME_W-1:0]     edge_time,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [mrcs_pkg::OUT_W-1:0]      best_ratio,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mrcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mrcs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mrcs_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// sequencer: adjacency build, bisection loop, queue-driven relaxation
	mrcs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .status(status), .cmd(cmd)
	);

	// memories, queue pointers, ratio bounds and the distance arithmetic
	mrcs_dp #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES(MAX_EDGES),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.vertex_id(vertex_id), .fun_value(fun_value),
		.edge_source(edge_source), .edge_target(edge_target),
		.edge_time(edge_time),
		.out_valid(out_valid), .out_ready(out_ready), .best_ratio(best_ratio),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

endmodule

/* hw/rtl/mrcs_ram.sv */
module mrcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/mrcs_ctrl.sv */
module mrcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  mrcs_pkg::dp_status_t status,
	output mrcs_pkg::ctrl_cmd_t  cmd
);
	import mrcs_pkg::*;

	op_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = state_q;
		unique case (state_q)
			OP_IDLE:  if (status.start) state_d = OP_HCLR;
			OP_HCLR:  if (status.sweep_last) state_d = OP_ARD;
			OP_ARD:   state_d = status.edges_done ? OP_BSET : OP_AHD;
			OP_AHD:   state_d = status.edge_in_graph ? OP_AWR : OP_ARD;
			OP_AWR:   state_d = OP_ARD;
			OP_BSET:  state_d = OP_MID;
			OP_MID:   state_d = status.iter_done ? OP_DONE : OP_PCLR;
			OP_PCLR:  if (status.sweep_last) state_d = OP_PINIT;
			OP_PINIT: state_d = OP_POP;
			OP_POP:   state_d = status.queue_empty ? OP_PEND : OP_PX;
			OP_PX:    state_d = OP_PX2;
			OP_PX2:   state_d = OP_PL;
			OP_PL:    state_d = status.link_zero ? OP_POP : OP_PE;
			OP_PE:    state_d = OP_PW;
			OP_PW:    state_d = OP_PC;
			OP_PC:    state_d = status.found ? OP_PEND : OP_PL;
			OP_PEND:  state_d = OP_MID;
			OP_DONE:  if (!status.out_busy) state_d = OP_IDLE;
			default:  state_d = OP_IDLE;
		endcase
	end

endmodule

/* hw/rtl/mrcs_dp.sv */
module mrcs_dp #(
	parameter int MAX_VERTICES = mrcs_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = mrcs_pkg::DEF_MAX_EDGES,
	parameter int FRAC_BITS    = mrcs_pkg::DEF_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mrcs_pkg::ctrl_cmd_t                 cmd,
	output mrcs_pkg::dp_status_t                status,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mrcs_pkg::KIND_W-1:0]         kind,
	input  logic [mrcs_pkg::ID_W-1:0]           vertex_id,
	input  logic [mrcs_pkg::VAL_W-1:0]          fun_value,
	input  logic [mrcs_pkg::ID_W-1:0]           edge_source,
	input  logic [mrcs_pkg::ID_W-1:0]           edge_target,
	input  logic [mrcs_pkg::TIME_W-1:0]         edge_time,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mrcs_pkg::OUT_W-1:0]          best_ratio,
	input  logic                                cfg_valid,
	input  logic [mrcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mrcs_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mrcs_pkg::*;

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int LW  = $clog2(MAX_EDGES + 1);
	localparam int IW  = (NW > LW) ? NW : LW;
	localparam int RW  = RATIO_INT_W + FRAC_BITS;
	localparam int PW  = RW + TIME_W;
	localparam int EDW = 2 * VW + TIME_W;
	localparam int SW  = 2 + NW;

	typedef struct packed {
		logic          reached;
		logic          queued;
		logic [NW-1:0] hop;
	} vstate_t;

	// configuration
	logic [VC_W-1:0]        vertex_count_q;
	logic [EC_W-1:0]        edge_count_q;
	logic [IT_W-1:0]        iter_count_q;
	logic [RATIO_INT_W-1:0] ratio_upper_q;

	// control registers
	logic [LW-1:0]     edge_cnt_q;
	logic [NW-1:0]     n_q;
	logic [LW-1:0]     m_q;
	logic [IW-1:0]     idx_q;
	logic [VW-1:0]     qhead_q, qtail_q;
	logic [NW-1:0]     qcount_q;
	logic [IT_W-1:0]   it_q;
	logic              found_q;
	logic              out_valid_q;

	// payload registers
	logic [RW-1:0]              lo_q, hi_q, mid_q;
	logic [VW-1:0]              s_q, x_q, y_q;
	logic [LW-1:0]              link_q, next_q;
	logic [NW-1:0]              hopx_q;
	logic signed [DIST_W-1:0]   distx_q, dy_q, cand_q;
	logic [VAL_W-1:0]           valx_q;
	logic [PW-1:0]              prod_q;
	vstate_t                    vy_q;
	logic [OUT_W-1:0]           best_q;

	// memory ports
	logic              val_we;
	logic [VW-1:0]     val_waddr;
	logic [VAL_W-1:0]  val_rdata;
	logic              edge_we;
	logic [EW-1:0]     edge_waddr, edge_raddr;
	logic [EDW-1:0]    edge_wdata, edge_rdata;
	logic              head_we;
	logic [VW-1:0]     head_waddr, head_raddr;
	logic [LW-1:0]     head_wdata, head_rdata;
	logic              next_we;
	logic [LW-1:0]     next_rdata;
	logic              vs_we;
	logic [VW-1:0]     vs_waddr, vs_raddr;
	vstate_t           vs_wdata, vs_rdata;
	logic              dist_we;
	logic [VW-1:0]     dist_waddr, dist_raddr;
	logic [DIST_W-1:0] dist_wdata, dist_rdata;
	logic              q_we;
	logic [VW-1:0]     q_waddr;
	logic [VW-1:0]     q_wdata, q_rdata;

	logic            accept;
	logic            vid_ok, edge_ok;
	logic [VW-1:0]   e_src, e_tgt;
	logic [TIME_W-1:0] e_time;
	logic            relax;
	logic [NW-1:0]   hop_new;
	logic            enqueue;
	logic [RW:0]     mid_sum;

	assign accept   = in_valid && (cmd.op == OP_IDLE);
	assign in_ready = (cmd.op == OP_IDLE);

	assign vid_ok  = (vertex_id != '0) && (32'(vertex_id) <= MAX_VERTICES);
	assign edge_ok = (edge_source != '0) && (32'(edge_source) <= MAX_VERTICES)
		&& (edge_target != '0) && (32'(edge_target) <= MAX_VERTICES)
		&& (32'(edge_cnt_q) < MAX_EDGES);

	assign e_src  = edge_rdata[EDW-1 -: VW];
	assign e_tgt  = edge_rdata[TIME_W +: VW];
	assign e_time = edge_rdata[TIME_W-1:0];

	// relaxation decision on the candidate distance
	assign relax   = !vy_q.reached || (dy_q > cand_q);
	assign hop_new = hopx_q + 1'b1;
	assign enqueue = relax && !vy_q.queued && (32'(qcount_q) < MAX_VERTICES);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

	always_comb begin
		status               = '0;
		status.start         = accept && (kind == KIND_START);
		status.sweep_last    = (NW'(idx_q) == n_q - 1'b1);
		status.edges_done    = (LW'(idx_q) >= m_q);
		status.edge_in_graph = (NW'(e_src) < n_q) && (NW'(e_tgt) < n_q);
		status.iter_done     = (it_q == iter_count_q);
		status.queue_empty   = (qcount_q == '0);
		status.link_zero     = (link_q == '0);
		status.found         = relax && (hop_new >= n_q);
		status.out_busy      = out_valid_q;
	end

	// load writes
	assign val_we     = accept && (kind == KIND_VERTEX) && vid_ok;
	assign val_waddr  = VW'(vertex_id - 1'b1);
	assign edge_we    = accept && (kind == KIND_EDGE) && edge_ok;
	assign edge_waddr = EW'(edge_cnt_q);
	assign edge_wdata = {VW'(edge_source - 1'b1), VW'(edge_target - 1'b1), edge_time};

	// memory address steering
	always_comb begin
		edge_raddr = EW'(idx_q);
		head_we    = 1'b0;
		head_waddr = s_q;
		head_wdata = '0;
		head_raddr = q_rdata;
		next_we    = 1'b0;
		vs_we      = 1'b0;
		vs_waddr   = y_q;
		vs_wdata   = '0;
		vs_raddr   = q_rdata;
		dist_we    = 1'b0;
		dist_waddr = y_q;
		dist_wdata = cand_q;
		dist_raddr = q_rdata;
		q_we       = 1'b0;
		q_waddr    = qtail_q;
		q_wdata    = y_q;
		unique case (cmd.op)
			OP_HCLR: begin
				head_we    = 1'b1;
				head_waddr = VW'(idx_q);
			end
			OP_AHD: begin
				head_raddr = e_src;
			end
			OP_AWR: begin
				head_we    = 1'b1;
				head_wdata = LW'(idx_q) + 1'b1;
				next_we    = 1'b1;
			end
			OP_PCLR: begin
				vs_we    = 1'b1;
				vs_waddr = VW'(idx_q);
			end
			OP_PINIT: begin
				vs_we      = 1'b1;
				vs_waddr   = '0;
				vs_wdata   = '{reached: 1'b1, queued: 1'b1, hop: '0};
				dist_we    = 1'b1;
				dist_waddr = '0;
				dist_wdata = '0;
				q_we       = 1'b1;
				q_waddr    = '0;
				q_wdata    = '0;
			end
			OP_PX2: begin
				vs_we    = 1'b1;
				vs_waddr = x_q;
				vs_wdata = '{reached: 1'b1, queued: 1'b0, hop: vs_rdata.hop};
			end
			OP_PL: begin
				edge_raddr = EW'(link_q - 1'b1);
			end
			OP_PE: begin
				vs_raddr   = e_tgt;
				dist_raddr = e_tgt;
			end
			OP_PC: begin
				vs_we    = relax;
				vs_wdata = '{reached: 1'b1, queued: vy_q.queued || enqueue, hop: hop_new};
				dist_we  = relax;
				q_we     = enqueue && !status.found;
			end
			default: begin
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= RST_VERTEX_COUNT;
			edge_count_q   <= RST_EDGE_COUNT;
			iter_count_q   <= RST_ITER_COUNT;
			ratio_upper_q  <= RST_RATIO_UPPER;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VERTEX_COUNT: vertex_count_q <= VC_W'(cfg_data);
				REG_EDGE_COUNT:   edge_count_q   <= EC_W'(cfg_data);
				REG_ITER_COUNT:   iter_count_q   <= IT_W'(cfg_data);
				REG_RATIO_UPPER:  ratio_upper_q  <= RATIO_INT_W'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cnt_q  <= '0;
			n_q         <= NW'(1);
			m_q         <= '0;
			idx_q       <= '0;
			qhead_q     <= '0;
			qtail_q     <= '0;
			qcount_q    <= '0;
			it_q        <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (cmd.op)
				OP_IDLE: begin
					if (edge_we) begin
						edge_cnt_q <= edge_cnt_q + 1'b1;
					end
					if (status.start) begin
						idx_q <= '0;
						if (vertex_count_q == '0) begin
							n_q <= NW'(1);
						end else if (32'(vertex_count_q) > MAX_VERTICES) begin
							n_q <= NW'(MAX_VERTICES);
						end else begin
							n_q <= NW'(vertex_count_q);
						end
						if (32'(edge_count_q) > 32'(edge_cnt_q)) begin
							m_q <= edge_cnt_q;
						end else begin
							m_q <= LW'(edge_count_q);
						end
					end
				end
				OP_HCLR, OP_PCLR: begin
					idx_q <= status.sweep_last ? '0 : idx_q + 1'b1;
				end
				OP_AHD: begin
					if (!status.edge_in_graph) begin
						idx_q <= idx_q + 1'b1;
					end
				end
				OP_AWR: idx_q <= idx_q + 1'b1;
				OP_BSET: it_q <= '0;
				OP_MID: idx_q <= '0;
				OP_PINIT: begin
					qhead_q  <= '0;
					qtail_q  <= (32'(1) == MAX_VERTICES) ? '0 : VW'(1);
					qcount_q <= NW'(1);
					found_q  <= 1'b0;
				end
				OP_POP: begin
					if (!status.queue_empty) begin
						qhead_q  <= (32'(qhead_q) == MAX_VERTICES - 1) ? '0 : qhead_q + 1'b1;
						qcount_q <= qcount_q - 1'b1;
					end
				end
				OP_PC: begin
					if (status.found) begin
						found_q <= 1'b1;
					end else if (enqueue) begin
						qtail_q  <= (32'(qtail_q) == MAX_VERTICES - 1) ? '0 : qtail_q + 1'b1;
						qcount_q <= qcount_q + 1'b1;
					end
				end
				OP_PEND: it_q <= it_q + 1'b1;
				OP_DONE: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						edge_cnt_q  <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_AHD: s_q <= e_src;
			OP_BSET: begin
				lo_q <= '0;
				hi_q <= {ratio_upper_q, {FRAC_BITS{1'b0}}};
			end
			OP_MID: mid_q <= mid_sum[RW:1];
			OP_PX: x_q <= q_rdata;
			OP_PX2: begin
				link_q  <= head_rdata;
				hopx_q  <= vs_rdata.hop;
				distx_q <= dist_rdata;
				valx_q  <= val_rdata;
			end
			OP_PE: begin
				y_q    <= e_tgt;
				next_q <= next_rdata;
				prod_q <= PW'(mid_q) * PW'(e_time);
			end
			OP_PW: begin
				cand_q <= distx_q + DIST_W'(prod_q)
					- DIST_W'({valx_q, {FRAC_BITS{1'b0}}});
				vy_q   <= vs_rdata;
				dy_q   <= dist_rdata;
			end
			OP_PC: begin
				link_q <= next_q;
				// a self loop changes the source vertex itself
				if (relax && (y_q == x_q)) begin
					distx_q <= cand_q;
					hopx_q  <= hop_new;
				end
			end
			OP_PEND: begin
				if (found_q) begin
					lo_q <= mid_q;
				end else begin
					hi_q <= mid_q;
				end
			end
			OP_DONE: begin
				if (!out_valid_q) begin
					best_q <= OUT_W'(lo_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign best_ratio = best_q;

	mrcs_ram #(.WIDTH(VAL_W), .DEPTH(MAX_VERTICES)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(val_waddr), .wdata(fun_value),
		.raddr(q_rdata), .rdata(val_rdata)
	);

	mrcs_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);

	mrcs_ram #(.WIDTH(LW), .DEPTH(MAX_VERTICES)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);

	mrcs_ram #(.WIDTH(LW), .DEPTH(MAX_EDGES)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(EW'(idx_q)), .wdata(head_rdata),
		.raddr(edge_raddr), .rdata(next_rdata)
	);

	mrcs_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_vstate_ram (
		.clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
		.raddr(vs_raddr), .rdata(vs_rdata)
	);

	mrcs_ram #(.WIDTH(DIST_W), .DEPTH(MAX_VERTICES)) u_dist_ram (
		.clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(dist_raddr), .rdata(dist_rdata)
	);

	mrcs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_queue_ram (
		.clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
		.raddr(qhead_q), .rdata(q_rdata)
	);

endmodule

/* hw/rtl/mrcs_checker.sv */
module mrcs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [mrcs_pkg::KIND_W-1:0]     kind,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [mrcs_pkg::OUT_W-1:0]      best_ratio
);
	import mrcs_pkg::*;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_ratio))
		else $error("result word changed while stalled");

	// a start word makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_START |=> !in_ready)
		else $error("input still ready after start");

	// loads never leave the idle state
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind != KIND_START |=> in_ready)
		else $error("load word made the block busy");

	// a result only appears at the end of a search
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result word without a search");

endmodule

bind max_ratio_cycle_search mrcs_checker u_mrcs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.kind(kind), .out_valid(out_valid), .out_ready(out_ready),
	.best_ratio(best_ratio)
);
